/* rtl/lgs_pkg.sv */
`timescale 1ns / 1ps
package lgs_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    // padded position counters must hold max + 1
    localparam int POS_W      = $clog2(MAX_DIM + 2);
    localparam int LS_AW      = $clog2(LINE_DEPTH);
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int IDX_W      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic             next_live;
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic             frame_done;
    } t_res;

    // line store access for one accepted cell: write at current column,
    // read ahead at the column of the next cell
    typedef struct packed {
        logic             en;
        logic [LS_AW-1:0] wr_addr;
        logic [1:0]       wr_data;   // [1] upper (old middle), [0] middle (new cell)
        logic [LS_AW-1:0] rd_addr;
    } t_ls_ctrl;

    // 0 acts as 1, anything above the maximum acts as the maximum
    function automatic logic [POS_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input int max_v);
        logic [POS_W-1:0] res;
        if (v == '0) begin
            res = POS_W'(1);
        end else if (v > CFG_W'(max_v)) begin
            res = POS_W'(max_v);
        end else begin
            res = POS_W'(v);
        end
        return res;
    endfunction

endpackage

/* rtl/lgs_cell_if.sv */
`timescale 1ns / 1ps
interface lgs_cell_if;
    logic valid;
    logic ready;
    logic cell_live;
    logic frame_start;

    modport source (output valid, output cell_live, output frame_start, input ready);
    modport sink   (input valid, input cell_live, input frame_start, output ready);
endinterface

/* rtl/lgs_res_if.sv */
`timescale 1ns / 1ps
interface lgs_res_if;
    logic                        valid;
    logic                        ready;
    logic                        next_live;
    logic [lgs_pkg::IDX_W-1:0]   out_row;
    logic [lgs_pkg::IDX_W-1:0]   out_col;
    logic                        frame_done;

    modport source (output valid, output next_live, output out_row, output out_col,
                    output frame_done, input ready);
    modport sink   (input valid, input next_live, input out_row, input out_col,
                    input frame_done, output ready);
endinterface

/* rtl/lgs_cfg_if.sv */
`timescale 1ns / 1ps
interface lgs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lgs_pkg::CFG_IDX_W-1:0] index;
    logic [lgs_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/lgs_line_store.sv */
`timescale 1ns / 1ps
module lgs_line_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lgs_pkg::t_ls_ctrl    i_ctrl,
    output logic [1:0]           o_rd_data
);

    logic [1:0]                     r_mem [lgs_pkg::LINE_DEPTH];
    logic [lgs_pkg::LINE_DEPTH-1:0] r_valid;
    logic [1:0]                     r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_mem[i_ctrl.wr_addr] <= i_ctrl.wr_data;
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_data <= '0;
        end else if (i_ctrl.en) begin
            r_valid[i_ctrl.wr_addr] <= 1'b1;
            // next address never equals the write address, so no bypass
            r_rd_data <= r_valid[i_ctrl.rd_addr] ? r_mem[i_ctrl.rd_addr] : 2'b00;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/lgs_win_cell.sv */
`timescale 1ns / 1ps
module lgs_win_cell (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic [2:0] i_col,
    output logic [2:0] o_col,
    output logic [1:0] o_sum
);

    logic [2:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
    assign o_sum = 2'(r_col[0]) + 2'(r_col[1]) + 2'(r_col[2]);

endmodule

/* rtl/life_generation_stencil.sv */
`timescale 1ns / 1ps
// channel  dir  fields                                  transfer when
// i_cell   in   cell_live, frame_start                  i_cell.valid & i_cell.ready
// o_res    out  next_live, out_row, out_col, frame_done o_res.valid & o_res.ready
// i_cfg    in   index (0 rows_in_use, 1 cols_in_use), data  i_cfg.valid & i_cfg.ready
//
// One padded-frame cell per cycle while i_cell is ready; the result of an
// interior cell is registered at its transfer. The line store is read one cell
// ahead through its registered port, so each cell is taken without a wait.
// Reset clears counters, window and line store valid bits; no clearing pass.
// A two-entry output stage keeps i_cell ready while one result waits.
module life_generation_stencil (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgs_cell_if.sink    i_cell,
    lgs_res_if.source   o_res,
    lgs_cfg_if.sink     i_cfg
);

    logic [lgs_pkg::CFG_W-1:0] r_rows_cfg;
    logic [lgs_pkg::CFG_W-1:0] r_cols_cfg;
    logic [lgs_pkg::POS_W-1:0] r_row, r_col;
    logic [lgs_pkg::POS_W-1:0] n_row, n_col;

    logic [lgs_pkg::POS_W-1:0] rows, cols, row_last, col_last;
    logic [lgs_pkg::POS_W-1:0] cur_row, cur_col;
    logic                      in_fire, border, live, emit;
    logic [1:0]                ls_rd;
    logic                      up, mid;
    logic [2:0]                new_col, c0_col, c1_col;
    logic [1:0]                c0_sum, c1_sum;
    logic [3:0]                count;
    logic                      centre, nxt;
    lgs_pkg::t_ls_ctrl         ls_ctrl;
    lgs_pkg::t_res             res;

    logic                      r_out_valid, r_skid_valid;
    lgs_pkg::t_res             r_out, r_skid;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= lgs_pkg::CFG_W'(lgs_pkg::MAX_ROWS);
            r_cols_cfg <= lgs_pkg::CFG_W'(lgs_pkg::MAX_COLS);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == lgs_pkg::CFG_ROWS) begin
                r_rows_cfg <= i_cfg.data;
            end
            if (i_cfg.index == lgs_pkg::CFG_COLS) begin
                r_cols_cfg <= i_cfg.data;
            end
        end
    end

    assign rows     = lgs_pkg::clamp_size(r_rows_cfg, lgs_pkg::MAX_ROWS);
    assign cols     = lgs_pkg::clamp_size(r_cols_cfg, lgs_pkg::MAX_COLS);
    assign row_last = rows + lgs_pkg::POS_W'(1);
    assign col_last = cols + lgs_pkg::POS_W'(1);

    // position
    assign in_fire = i_cell.valid && i_cell.ready;
    assign cur_row = i_cell.frame_start ? '0 : r_row;
    assign cur_col = i_cell.frame_start ? '0 : r_col;

    assign border = (cur_row == '0) || (cur_row >= row_last) ||
                    (cur_col == '0) || (cur_col >= col_last);
    assign live   = !border && i_cell.cell_live;

    always_comb begin
        if (cur_col >= col_last) begin
            n_col = '0;
            n_row = (cur_row >= row_last) ? '0 : cur_row + lgs_pkg::POS_W'(1);
        end else begin
            n_col = cur_col + lgs_pkg::POS_W'(1);
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_fire) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // line store; column 0 is always border, so its entry stays zero
    assign ls_ctrl.en      = in_fire;
    assign ls_ctrl.wr_addr = lgs_pkg::LS_AW'(cur_col);
    assign ls_ctrl.wr_data = {mid, live};
    assign ls_ctrl.rd_addr = lgs_pkg::LS_AW'(n_col);

    lgs_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ls_ctrl),
        .o_rd_data (ls_rd)
    );

    assign up  = !i_cell.frame_start && ls_rd[1];
    assign mid = !i_cell.frame_start && ls_rd[0];

    // window: bit0 top, bit1 middle, bit2 bottom; two held columns behind the new one
    assign new_col = {live, mid, up};

    lgs_win_cell u_win_c0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_fire),
        .i_col   (new_col),
        .o_col   (c0_col),
        .o_sum   (c0_sum)
    );

    lgs_win_cell u_win_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_fire),
        .i_col   (c0_col),
        .o_col   (c1_col),
        .o_sum   (c1_sum)
    );

    assign centre = c0_col[1];
    assign count  = 4'(new_col[0]) + 4'(new_col[1]) + 4'(new_col[2]) +
                    4'(c0_sum) - 4'(centre) + 4'(c1_sum);
    assign nxt    = centre ? ((count == 4'd2) || (count == 4'd3)) : (count == 4'd3);

    assign emit = (cur_row >= lgs_pkg::POS_W'(2)) && (cur_col >= lgs_pkg::POS_W'(2)) &&
                  (cur_row <= row_last) && (cur_col <= col_last);

    assign res.next_live  = nxt;
    assign res.out_row    = lgs_pkg::IDX_W'(cur_row - lgs_pkg::POS_W'(2));
    assign res.out_col    = lgs_pkg::IDX_W'(cur_col - lgs_pkg::POS_W'(2));
    assign res.frame_done = (cur_row == row_last) && (cur_col == col_last);

    // output register with skid entry
    assign i_cell.ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid  <= r_skid_valid || (in_fire && emit);
            r_skid_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_res.ready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire && emit) begin
            r_skid <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.next_live  = r_out.next_live;
    assign o_res.out_row    = r_out.out_row;
    assign o_res.out_col    = r_out.out_col;
    assign o_res.frame_done = r_out.frame_done;

endmodule

/* rtl/lgs_checker.sv */
`timescale 1ns / 1ps
module lgs_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cell_ready,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic                        i_res_next_live,
    input  logic [lgs_pkg::IDX_W-1:0]   i_res_out_row,
    input  logic [lgs_pkg::IDX_W-1:0]   i_res_out_col,
    input  logic                        i_res_frame_done
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // input only backs up when both output entries hold results
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell_ready |-> i_res_valid)
        else $error("input stalled with no pending result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && !i_cell_ready) |-> $past(i_res_valid && !i_res_ready))
        else $error("input stalled without a held result");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_next_live) &&
            $stable(i_res_out_row) && $stable(i_res_out_col) &&
            $stable(i_res_frame_done)))
        else $error("held result changed");

endmodule

bind life_generation_stencil lgs_checker u_lgs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cell_ready     (i_cell.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_next_live  (o_res.next_live),
    .i_res_out_row    (o_res.out_row),
    .i_res_out_col    (o_res.out_col),
    .i_res_frame_done (o_res.frame_done)
);
